/* rtl/rgb_led_ring_frame_builder_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros shared by the LED ring frame builder RTL.
// They use clk_i and rst_ni of the module that expands them.
// ---------------------------------------------------------------------------
`ifndef RGB_LED_RING_FRAME_BUILDER_DEFINES_SVH
`define RGB_LED_RING_FRAME_BUILDER_DEFINES_SVH

// Same-cycle implication.
`define RLFB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RLFB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rlfb_pkg.sv */
// ---------------------------------------------------------------------------
// rlfb_pkg
// Types, constants and helpers of the LED ring frame builder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rlfb_pkg;

  localparam int unsigned LED_COUNT_DEF   = 12;
  localparam int unsigned CURVE_STEPS_DEF = 101;

  localparam logic [6:0] PCT_MAX     = 7'd100;
  localparam logic [7:0] START_MARK  = 8'hE0;
  localparam int unsigned HDR_BYTES  = 4;

  // round(k*31/100) == ((k*31 + 50) * GLOB_RECIP) >> GLOB_SHIFT for k <= 100
  localparam logic [24:0] GLOB_RECIP = 25'd5243;
  localparam int unsigned GLOB_SHIFT = 19;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    MODE_LOAD      = 3'd0,
    MODE_STAGE_LED = 3'd1,
    MODE_STAGE_ALL = 3'd2,
    MODE_ROTATE    = 3'd3,
    MODE_COMMIT    = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    CMD_ACK,
    CMD_SET_ONE,
    CMD_SET_ALL,
    CMD_ROTATE,
    CMD_COMMIT
  } cmd_e;

  // Classified request handed from the front to the back.
  typedef struct packed {
    cmd_e        cmd;
    logic        err;
    logic [3:0]  idx;
    logic        dir;
    logic [4:0]  glob;
    logic [23:0] color;   // {blue, green, red}, already scaled
  } entry_t;

  // (c * f + 0.5) in Q1.16, saturated to 8 bits
  function automatic logic [7:0] scale_chan(input logic [7:0] c, input logic [16:0] f);
    logic [25:0] p;
    p = 26'(c) * 26'(f) + 26'd32768;
    return (p[25:24] != 2'b00) ? 8'hFF : p[23:16];
  endfunction

endpackage

`default_nettype wire

/* rtl/rlfb_front.sv */
// ---------------------------------------------------------------------------
// rlfb_front
// Accepts requests, owns the brightness curve, classifies each request and
// scales staged colors before handing them to the queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rlfb_front #(
  parameter int unsigned LED_COUNT   = rlfb_pkg::LED_COUNT_DEF,
  parameter int unsigned CURVE_STEPS = rlfb_pkg::CURVE_STEPS_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic [2:0]      mode_i,
  input  wire logic [3:0]      led_index_i,
  input  wire logic [23:0]     color_i,
  input  wire logic [6:0]      brightness_i,
  input  wire logic            direction_i,
  input  wire logic [6:0]      table_index_i,
  input  wire logic [16:0]     table_value_i,
  output logic                 push_o,
  output rlfb_pkg::entry_t     entry_o,
  input  wire logic            full_i
);
  import rlfb_pkg::*;

  localparam int unsigned CIDX_W = $clog2(CURVE_STEPS);

  logic                   accept;
  logic                   pend_q, pend_d;
  logic [6:0]             pct;
  logic [8:0]             rd_addr9, wr_addr9;
  logic [CIDX_W-1:0]      rd_addr, wr_addr;
  logic                   wr_en;
  logic [11:0]            glob_x;
  logic [24:0]            glob_p;
  cmd_e                   cmd_c;
  logic                   err_c;

  logic [16:0]            curve_mem [CURVE_STEPS];
  logic [CURVE_STEPS-1:0] cvld_q;
  logic [16:0]            f_q;
  logic                   fvld_q;
  logic [16:0]            fac;

  cmd_e                   cmd_q;
  logic                   err_q;
  logic [3:0]             idx_q;
  logic                   dir_q;
  logic [4:0]             glob_q;
  logic [23:0]            color_q;

  assign push_o     = pend_q && !full_i;
  assign in_stall_o = pend_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign pct      = (brightness_i > PCT_MAX) ? PCT_MAX : brightness_i;
  assign rd_addr9 = ({2'b00, pct} > 9'(CURVE_STEPS - 1)) ? 9'(CURVE_STEPS - 1)
                                                         : {2'b00, pct};
  assign rd_addr  = rd_addr9[CIDX_W-1:0];
  assign wr_addr9 = {2'b00, table_index_i};
  assign wr_addr  = wr_addr9[CIDX_W-1:0];
  assign wr_en    = accept && (mode_i == MODE_LOAD) && (wr_addr9 < 9'(CURVE_STEPS));

  assign glob_x = 12'(pct) * 12'd31 + 12'd50;
  assign glob_p = 25'(glob_x) * GLOB_RECIP;

  always_comb begin
    cmd_c = CMD_ACK;
    err_c = 1'b0;
    unique case (mode_e'(mode_i))
      MODE_LOAD: begin
        cmd_c = CMD_ACK;
      end
      MODE_STAGE_LED: begin
        if ({1'b0, led_index_i} < 5'(LED_COUNT)) begin
          cmd_c = CMD_SET_ONE;
        end else begin
          err_c = 1'b1;
        end
      end
      MODE_STAGE_ALL: begin
        cmd_c = CMD_SET_ALL;
      end
      MODE_ROTATE: begin
        cmd_c = CMD_ROTATE;
      end
      MODE_COMMIT: begin
        cmd_c = CMD_COMMIT;
      end
      default: begin
        err_c = 1'b1;
      end
    endcase
  end

  assign pend_d = accept ? 1'b1 : (push_o ? 1'b0 : pend_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      cvld_q <= '0;
    end else begin
      pend_q <= pend_d;
      if (wr_en) begin
        cvld_q[wr_addr] <= 1'b1;
      end
    end
  end

  // curve memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      curve_mem[wr_addr] <= table_value_i;
    end
    if (accept) begin
      f_q     <= curve_mem[rd_addr];
      fvld_q  <= cvld_q[rd_addr];
      cmd_q   <= cmd_c;
      err_q   <= err_c;
      idx_q   <= led_index_i;
      dir_q   <= direction_i;
      glob_q  <= glob_p[GLOB_SHIFT+4:GLOB_SHIFT];
      color_q <= color_i;
    end
  end

  assign fac = fvld_q ? f_q : 17'd0;

  always_comb begin
    entry_o.cmd   = cmd_q;
    entry_o.err   = err_q;
    entry_o.idx   = idx_q;
    entry_o.dir   = dir_q;
    entry_o.glob  = glob_q;
    entry_o.color = {scale_chan(color_q[23:16], fac),
                     scale_chan(color_q[15:8], fac),
                     scale_chan(color_q[7:0], fac)};
  end

endmodule

`default_nettype wire

/* rtl/rlfb_queue.sv */
// ---------------------------------------------------------------------------
// rlfb_queue
// Short FIFO of classified requests between front and back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rlfb_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire rlfb_pkg::entry_t  entry_i,
  output logic                   full_o,
  output logic                   valid_o,
  output rlfb_pkg::entry_t       entry_o,
  input  wire logic              pop_i
);
  import rlfb_pkg::*;

  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);

  entry_t            slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QPTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign entry_o = slots_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/rlfb_back.sv */
// ---------------------------------------------------------------------------
// rlfb_back
// Holds the staged LED colors, applies requests and serializes the frame
// into the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_led_ring_frame_builder_defines.svh"

module rlfb_back #(
  parameter int unsigned LED_COUNT = rlfb_pkg::LED_COUNT_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_valid_i,
  input  wire rlfb_pkg::entry_t  entry_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   kind_o,
  output logic [7:0]             frame_byte_o,
  output logic                   error_o,
  output logic                   last_o
);
  import rlfb_pkg::*;

  localparam int unsigned LED_IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HDR  = 2'd1;
  localparam logic [1:0] S_LED  = 2'd2;
  localparam logic [1:0] S_TRL  = 2'd3;

  localparam logic [1:0] SUB_START = 2'd0;
  localparam logic [1:0] SUB_BLUE  = 2'd1;
  localparam logic [1:0] SUB_GREEN = 2'd2;
  localparam logic [1:0] SUB_RED   = 2'd3;

  logic [23:0]          colors_q [LED_COUNT];
  logic [23:0]          colors_d [LED_COUNT];
  logic                 any_q, any_c;
  logic [1:0]           state_q, state_d;
  logic [1:0]           cnt_q, cnt_d;
  logic [LED_IDX_W-1:0] led_q, led_d;
  logic [4:0]           cglob_q, cglob_d;
  logic                 adv;
  logic [23:0]          cur;

  logic                 o_valid_q, o_valid_d;
  logic                 o_kind_q, o_kind_d;
  logic [7:0]           o_byte_q, o_byte_d;
  logic                 o_err_q, o_err_d;
  logic                 o_last_q, o_last_d;

  assign adv = !o_valid_q || !out_stall_i;
  assign cur = colors_q[led_q];

  always_comb begin
    any_c = 1'b0;
    for (int i = 0; i < LED_COUNT; i++) begin
      any_c = any_c | (colors_q[i] != 24'd0);
    end
  end

  always_comb begin
    for (int i = 0; i < LED_COUNT; i++) begin
      colors_d[i] = colors_q[i];
    end
    state_d   = state_q;
    cnt_d     = cnt_q;
    led_d     = led_q;
    cglob_d   = cglob_q;
    pop_o     = 1'b0;
    o_valid_d = o_valid_q && out_stall_i;
    o_kind_d  = o_kind_q;
    o_byte_d  = o_byte_q;
    o_err_d   = o_err_q;
    o_last_d  = o_last_q;
    if (adv) begin
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            pop_o = 1'b1;
            if (entry_i.cmd == CMD_COMMIT) begin
              state_d = S_HDR;
              cnt_d   = 2'd0;
              cglob_d = entry_i.glob;
            end else begin
              o_valid_d = 1'b1;
              o_kind_d  = 1'b0;
              o_byte_d  = 8'd0;
              o_err_d   = entry_i.err;
              o_last_d  = 1'b1;
              unique case (entry_i.cmd)
                CMD_SET_ONE: begin
                  colors_d[entry_i.idx[LED_IDX_W-1:0]] = entry_i.color;
                end
                CMD_SET_ALL: begin
                  for (int i = 0; i < LED_COUNT; i++) begin
                    colors_d[i] = entry_i.color;
                  end
                end
                CMD_ROTATE: begin
                  for (int i = 0; i < LED_COUNT; i++) begin
                    if (entry_i.dir) begin
                      colors_d[i] = colors_q[(i == 0) ? LED_COUNT - 1 : i - 1];
                    end else begin
                      colors_d[i] = colors_q[(i == LED_COUNT - 1) ? 0 : i + 1];
                    end
                  end
                end
                default: begin
                end
              endcase
            end
          end
        end
        S_HDR: begin
          o_valid_d = 1'b1;
          o_kind_d  = 1'b1;
          o_byte_d  = 8'd0;
          o_err_d   = 1'b0;
          o_last_d  = 1'b0;
          cnt_d     = cnt_q + 2'd1;
          if (cnt_q == 2'(HDR_BYTES - 1)) begin
            state_d = S_LED;
            led_d   = '0;
          end
        end
        S_LED: begin
          o_valid_d = 1'b1;
          o_kind_d  = 1'b1;
          o_err_d   = 1'b0;
          o_last_d  = 1'b0;
          cnt_d     = cnt_q + 2'd1;
          unique case (cnt_q)
            SUB_START: o_byte_d = START_MARK | {3'b000, (any_q ? cglob_q : 5'd0)};
            SUB_BLUE:  o_byte_d = cur[23:16];
            SUB_GREEN: o_byte_d = cur[15:8];
            SUB_RED: begin
              o_byte_d = cur[7:0];
              if (led_q == LED_IDX_W'(LED_COUNT - 1)) begin
                state_d = S_TRL;
              end else begin
                led_d = led_q + 1'b1;
              end
            end
            default: o_byte_d = 8'd0;
          endcase
        end
        S_TRL: begin
          o_valid_d = 1'b1;
          o_kind_d  = 1'b1;
          o_byte_d  = 8'd0;
          o_err_d   = 1'b0;
          o_last_d  = 1'b1;
          state_d   = S_IDLE;
        end
        default: begin
          state_d = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      led_q     <= '0;
      any_q     <= 1'b0;
      o_valid_q <= 1'b0;
      for (int i = 0; i < LED_COUNT; i++) begin
        colors_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      led_q     <= led_d;
      any_q     <= any_c;
      o_valid_q <= o_valid_d;
      for (int i = 0; i < LED_COUNT; i++) begin
        colors_q[i] <= colors_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cglob_q  <= cglob_d;
    o_kind_q <= o_kind_d;
    o_byte_q <= o_byte_d;
    o_err_q  <= o_err_d;
    o_last_q <= o_last_d;
  end

  assign out_valid_o  = o_valid_q;
  assign kind_o       = o_kind_q;
  assign frame_byte_o = o_byte_q;
  assign error_o      = o_err_q;
  assign last_o       = o_last_q;

  `RLFB_ASSERT_NOW(a_ack_is_last, o_valid_q && !o_kind_q, o_last_q, "ack without last")
  `RLFB_ASSERT_NOW(a_frame_no_err, o_valid_q && o_kind_q, !o_err_q, "frame byte flagged error")
  `RLFB_ASSERT_NEXT(a_start_mark, (state_q == S_LED) && (cnt_q == SUB_START) && adv, o_valid_q && (o_byte_q[7:5] == 3'b111), "LED start byte lacks marker")
  `RLFB_ASSERT_NEXT(a_pop_acts, pop_o, (state_q == S_HDR) || o_valid_q, "popped request produced nothing")

endmodule

`default_nettype wire

/* rtl/rgb_led_ring_frame_builder.sv */
// ---------------------------------------------------------------------------
// rgb_led_ring_frame_builder
// Stages scaled LED colors through a loadable brightness curve and emits
// APA102 frames as a byte stream.
// ---------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------------
//  in      | sink      | in_valid_i/in_stall_o  | mode, led_index, color, brightness,
//          |           |                        | direction, table_index, table_value
//  out     | source    | out_valid_o/out_stall_i| kind, frame_byte, error, last
//
//  A non-commit request yields one acknowledgement after it is accepted; a
//  commit yields 4*LED_COUNT+5 bytes, one per cycle while out_stall_i does
//  not hold them, after the back end pops it, and holds the back end until
//  the last byte. The byte serializer in the back end sets the sustained rate.
//  The front takes one request per cycle while the 2-entry queue has room.
//  Reset clears the staged colors and the per-entry curve valid bits at once;
//  an unloaded curve entry reads as zero. No clearing pass.
//  out_stall_i holds the output register and, through it, the back end;
//  in_stall_o rises only when the front holds a request and the queue is full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgb_led_ring_frame_builder #(
  parameter int unsigned LED_COUNT   = rlfb_pkg::LED_COUNT_DEF,
  parameter int unsigned CURVE_STEPS = rlfb_pkg::CURVE_STEPS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  mode_i,
  input  wire logic [3:0]  led_index_i,
  input  wire logic [23:0] color_i,
  input  wire logic [6:0]  brightness_i,
  input  wire logic        direction_i,
  input  wire logic [6:0]  table_index_i,
  input  wire logic [16:0] table_value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             kind_o,
  output logic [7:0]       frame_byte_o,
  output logic             error_o,
  output logic             last_o
);
  import rlfb_pkg::*;

  // front -> queue
  logic   push;
  entry_t push_entry;
  logic   q_full;
  // queue -> back
  logic   q_valid;
  entry_t head_entry;
  logic   pop;

  rlfb_front #(
    .LED_COUNT   (LED_COUNT),
    .CURVE_STEPS (CURVE_STEPS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .led_index_i   (led_index_i),
    .color_i       (color_i),
    .brightness_i  (brightness_i),
    .direction_i   (direction_i),
    .table_index_i (table_index_i),
    .table_value_i (table_value_i),
    .push_o        (push),
    .entry_o       (push_entry),
    .full_i        (q_full)
  );

  rlfb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .entry_o (head_entry),
    .pop_i   (pop)
  );

  // back end: color store, request execution, frame serializer
  rlfb_back #(
    .LED_COUNT (LED_COUNT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .entry_i      (head_entry),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .frame_byte_o (frame_byte_o),
    .error_o      (error_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: LED ring frame builder testbench
// Drives requests of all five operations plus bad modes through the valid/
// stall input, predicts the acknowledgements and APA102 frame bytes from a
// private model of the ring and the curve table, and checks every result
// in order. Both sides idle at random; the receiver also holds off long
// enough to back the block up into its input.
// ---------------------------------------------------------------------------

module tb_top;
  import rlfb_pkg::*;

  localparam int unsigned LEDS        = LED_COUNT_DEF;
  localparam int unsigned STEPS       = CURVE_STEPS_DEF;
  localparam int unsigned GLOB_FULL   = 31;   // 5-bit global at 100 percent
  localparam int unsigned MAX_IDLE    = 16;
  localparam int unsigned HOLD_CYCLES = 300;  // long receiver hold-off
  localparam int unsigned STUCK_LIMIT = 3000; // cycles with no handshake at all
  localparam int unsigned DRAIN_TAIL  = 16;

  // Modes past commit are illegal and answered with an error ack.
  localparam logic [2:0] MODE_BAD_MIN = 3'd5;
  localparam logic [2:0] MODE_BAD_MAX = 3'd7;

  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_BYTE = 1'b1;

  typedef struct {
    logic [2:0]  mode;
    logic [3:0]  led_index;
    logic [23:0] color;
    logic [6:0]  brightness;
    logic        direction;
    logic [6:0]  table_index;
    logic [16:0] table_value;
  } request_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] frame_byte;
    logic       error;
    logic       last;
  } frame_result_t;

  // -------------------------------------------------------------------------
  // Scoreboard: own copy of the staged ring and the curve, plus the queue of
  // results still owed by the block.
  // -------------------------------------------------------------------------
  class frame_scoreboard;
    logic [23:0]   ring_rgb [LEDS];
    logic [16:0]   curve_q16 [STEPS];
    frame_result_t owed_results [$];
    int            errors;

    function new();
      foreach (ring_rgb[i]) ring_rgb[i] = '0;
      foreach (curve_q16[i]) curve_q16[i] = '0;
      errors = 0;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    function int unsigned clip_percent(logic [6:0] b);
      return (b > PCT_MAX) ? PCT_MAX : b;
    endfunction

    // Q1.16 scale with round half up, saturating at full scale.
    function logic [7:0] dim_channel(int unsigned c, int unsigned f);
      int unsigned v;
      v = (c * f + 32'd32768) >> 16;
      return (v > 255) ? 8'hFF : 8'(v);
    endfunction

    function logic [23:0] dim_color(logic [23:0] c, logic [6:0] b);
      int unsigned k;
      int unsigned f;
      k = clip_percent(b);
      if (k > STEPS - 1) k = STEPS - 1;
      f = curve_q16[k];
      return {dim_channel(c[23:16], f), dim_channel(c[15:8], f), dim_channel(c[7:0], f)};
    endfunction

    function void owe_byte(logic [7:0] b, logic fin);
      owed_results.push_back('{KIND_BYTE, b, 1'b0, fin});
    endfunction

    function void note_request(request_t r);
      frame_result_t ack;
      logic [23:0]   keep;
      int unsigned   glob;
      bit            lit;
      ack = '{KIND_ACK, 8'h00, 1'b0, 1'b1};
      case (r.mode)
        MODE_LOAD: begin
          // out-of-range curve index is dropped without an error
          if (r.table_index < STEPS) curve_q16[r.table_index] = r.table_value;
        end
        MODE_STAGE_LED: begin
          if (r.led_index < LEDS) ring_rgb[r.led_index] = dim_color(r.color, r.brightness);
          else ack.error = 1'b1;
        end
        MODE_STAGE_ALL: begin
          keep = dim_color(r.color, r.brightness);
          foreach (ring_rgb[i]) ring_rgb[i] = keep;
        end
        MODE_ROTATE: begin
          if (!r.direction) begin
            keep = ring_rgb[0];
            for (int i = 0; i < LEDS - 1; i++) ring_rgb[i] = ring_rgb[i + 1];
            ring_rgb[LEDS - 1] = keep;
          end else begin
            keep = ring_rgb[LEDS - 1];
            for (int i = LEDS - 1; i > 0; i--) ring_rgb[i] = ring_rgb[i - 1];
            ring_rgb[0] = keep;
          end
        end
        MODE_COMMIT: begin
          glob = (clip_percent(r.brightness) * GLOB_FULL + 50) / 100;
          lit = 1'b0;
          foreach (ring_rgb[i]) if (ring_rgb[i] != '0) lit = 1'b1;
          if (!lit) glob = 0;  // dark ring: global forced off
          repeat (HDR_BYTES) owe_byte(8'h00, 1'b0);
          foreach (ring_rgb[i]) begin
            owe_byte(START_MARK | 8'(glob), 1'b0);
            owe_byte(ring_rgb[i][23:16], 1'b0);
            owe_byte(ring_rgb[i][15:8], 1'b0);
            owe_byte(ring_rgb[i][7:0], 1'b0);
          end
          owe_byte(8'h00, 1'b1);
          return;
        end
        default: ack.error = 1'b1;
      endcase
      owed_results.push_back(ack);
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t want;
      if (owed_results.size() == 0) begin
        $error("result with nothing owed: kind %0d byte %02h error %0d last %0d",
               got.kind, got.frame_byte, got.error, got.last);
        errors++;
        return;
      end
      want = owed_results.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        errors++;
      end
      if (got.frame_byte !== want.frame_byte) begin
        $error("frame_byte: expected %02h, got %02h", want.frame_byte, got.frame_byte);
        errors++;
      end
      if (got.error !== want.error) begin
        $error("error: expected %0d, got %0d", want.error, got.error);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Clock, reset and DUT
  // -------------------------------------------------------------------------
  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  mode_i;
  logic [3:0]  led_index_i;
  logic [23:0] color_i;
  logic [6:0]  brightness_i;
  logic        direction_i;
  logic [6:0]  table_index_i;
  logic [16:0] table_value_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        kind_o;
  logic [7:0]  frame_byte_o;
  logic        error_o;
  logic        last_o;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rgb_led_ring_frame_builder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .led_index_i   (led_index_i),
    .color_i       (color_i),
    .brightness_i  (brightness_i),
    .direction_i   (direction_i),
    .table_index_i (table_index_i),
    .table_value_i (table_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .frame_byte_o  (frame_byte_o),
    .error_o       (error_o),
    .last_o        (last_o)
  );

  frame_scoreboard sb = new();

  bit          tx_idle;         // sender draws random gaps when set
  bit          rx_idle;         // receiver draws random stalls when set
  int unsigned hold_cycles;     // one-shot long hold-off for the receiver
  int unsigned quiet_cycles;    // edges since the last handshake on either side
  logic [6:0]  curve_loaded [$]; // curve entries written so far, for staging

  // -------------------------------------------------------------------------
  // Monitor: both handshakes sampled on the same edge, pre-update values.
  // The input is noted before the output is checked; results never leave
  // on the edge that accepts their request.
  // -------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    request_t      req;
    frame_result_t res;
    bit            in_fire;
    bit            out_fire;
    in_fire  = rst_ni && in_valid_i && !in_stall_o;
    out_fire = rst_ni && out_valid_o && !out_stall_i;
    if (in_fire) begin
      req = '{mode_i, led_index_i, color_i, brightness_i, direction_i,
              table_index_i, table_value_i};
      sb.note_request(req);
    end
    if (out_fire) begin
      res = '{kind_o, frame_byte_o, error_o, last_o};
      sb.check_result(res);
    end
    quiet_cycles <= (in_fire || out_fire) ? 0 : quiet_cycles + 1;
  end

  // Watchdog: nothing moving for too long means a hang or a lost result.
  initial begin : watchdog
    wait (quiet_cycles >= STUCK_LIMIT);
    $error("no handshake for %0d cycles, %0d results still owed", STUCK_LIMIT, sb.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Receiver: one stall draw per result; a requested hold-off replaces the
  // draw once and is counted here.
  // -------------------------------------------------------------------------
  initial begin : receiver
    int unsigned n;
    bit          held;
    held        = 1'b0;
    out_stall_i = 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_cycles > 0 && !held) begin
        n    = hold_cycles;
        held = 1'b1;
      end else begin
        n = rx_idle ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i);
      while (!(out_valid_o && !out_stall_i) && (hold_cycles == 0 || held));
    end
  end

  // -------------------------------------------------------------------------
  // Sender
  // -------------------------------------------------------------------------
  // Valid stays high from one request to the next when there is no gap,
  // so it is never lowered and raised in the same step.
  task automatic send_req(input request_t r);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= r.mode;
    led_index_i   <= r.led_index;
    color_i       <= r.color;
    brightness_i  <= r.brightness;
    direction_i   <= r.direction;
    table_index_i <= r.table_index;
    table_value_i <= r.table_value;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_op(input logic [2:0] m, input logic [3:0] idx, input logic [23:0] col,
                         input logic [6:0] br, input logic dir, input logic [6:0] ti,
                         input logic [16:0] tv);
    request_t r;
    r = '{m, idx, col, br, dir, ti, tv};
    send_req(r);
  endtask

  // Pause the sender until every owed result is back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Mostly legal operations with random content; staging mostly picks
  // brightness values whose curve entry was loaded, so colors are not dark.
  function automatic request_t random_request();
    request_t    r;
    int unsigned pick;
    r.mode        = 3'($urandom);
    r.led_index   = 4'($urandom);
    r.color       = 24'($urandom);
    r.brightness  = 7'($urandom);
    r.direction   = 1'($urandom);
    r.table_index = 7'($urandom);
    r.table_value = 17'($urandom);
    if ($urandom_range(0, 9) == 0) r.color = '0;
    if (curve_loaded.size() > 0 && $urandom_range(0, 9) < 7)
      r.brightness = curve_loaded[$urandom_range(0, curve_loaded.size() - 1)];
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      r.mode = MODE_LOAD;
      if ($urandom_range(0, 9) != 0) r.table_index = 7'($urandom_range(0, STEPS - 1));
      // factors above 1.0 are rare but push channels into saturation
      if ($urandom_range(0, 3) != 0) r.table_value = 17'($urandom_range(0, 65536));
      if (r.table_index < STEPS) curve_loaded.push_back(r.table_index);
    end else if (pick < 50) begin
      r.mode = MODE_STAGE_LED;
      if ($urandom_range(0, 6) != 0) r.led_index = 4'($urandom_range(0, LEDS - 1));
    end else if (pick < 58) begin
      r.mode = MODE_STAGE_ALL;
    end else if (pick < 72) begin
      r.mode = MODE_ROTATE;
    end else if (pick < 90) begin
      r.mode = MODE_COMMIT;
      r.brightness = 7'($urandom);
    end else if (pick < 95) begin
      r.mode = 3'($urandom_range(MODE_BAD_MIN, MODE_BAD_MAX));
    end
    // the rest keeps the raw random mode as noise
    return r;
  endfunction

  task automatic send_random(input int unsigned count);
    repeat (count) send_req(random_request());
  endtask

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin : stimulus
    in_valid_i    = 1'b0;
    mode_i        = MODE_LOAD;
    led_index_i   = '0;
    color_i       = '0;
    brightness_i  = '0;
    direction_i   = 1'b0;
    table_index_i = '0;
    table_value_i = '0;
    tx_idle       = 1'b1;
    rx_idle       = 1'b1;
    rst_ni        = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: commit of the dark ring after reset, curve extremes,
    // out-of-range curve and LED indexes, saturation, rotations both ways,
    // global rounding near zero, illegal modes.
    send_op(MODE_COMMIT,    4'd0,  24'h000000, 7'd127, 1'b0, 7'd0,   17'd0);
    send_op(MODE_LOAD,      4'd0,  24'h000000, 7'd0,   1'b0, 7'd100, 17'd65536);
    send_op(MODE_LOAD,      4'd0,  24'h000000, 7'd0,   1'b0, 7'd0,   17'd0);
    send_op(MODE_LOAD,      4'd0,  24'h000000, 7'd0,   1'b0, 7'd50,  17'd32768);
    send_op(MODE_LOAD,      4'd0,  24'h000000, 7'd0,   1'b0, 7'd99,  17'h1FFFF);
    send_op(MODE_LOAD,      4'd0,  24'h000000, 7'd0,   1'b0, 7'd101, 17'h1FFFF);
    send_op(MODE_LOAD,      4'd0,  24'h000000, 7'd0,   1'b0, 7'd127, 17'd12345);
    send_op(MODE_STAGE_LED, 4'd0,  24'hFFFFFF, 7'd127, 1'b0, 7'd0,   17'd0);
    send_op(MODE_STAGE_LED, 4'd11, 24'h80C0FF, 7'd99,  1'b0, 7'd0,   17'd0);
    send_op(MODE_STAGE_LED, 4'd12, 24'hFFFFFF, 7'd100, 1'b0, 7'd0,   17'd0);
    send_op(MODE_STAGE_LED, 4'd15, 24'hFFFFFF, 7'd100, 1'b1, 7'd0,   17'd0);
    send_op(MODE_COMMIT,    4'd0,  24'h000000, 7'd100, 1'b0, 7'd0,   17'd0);
    send_op(MODE_ROTATE,    4'd0,  24'h000000, 7'd0,   1'b0, 7'd0,   17'd0);
    send_op(MODE_ROTATE,    4'd0,  24'h000000, 7'd0,   1'b1, 7'd0,   17'd0);
    send_op(MODE_ROTATE,    4'd0,  24'h000000, 7'd0,   1'b1, 7'd0,   17'd0);
    send_op(MODE_COMMIT,    4'd0,  24'h000000, 7'd50,  1'b0, 7'd0,   17'd0);
    send_op(MODE_STAGE_ALL, 4'd0,  24'h01FF7F, 7'd50,  1'b0, 7'd0,   17'd0);
    send_op(MODE_STAGE_LED, 4'd5,  24'h000000, 7'd0,   1'b0, 7'd0,   17'd0);
    send_op(MODE_COMMIT,    4'd0,  24'h000000, 7'd1,   1'b0, 7'd0,   17'd0);
    send_op(MODE_COMMIT,    4'd0,  24'h000000, 7'd2,   1'b0, 7'd0,   17'd0);
    for (int m = MODE_BAD_MIN; m <= MODE_BAD_MAX; m++)
      send_op(3'(m), 4'd3, 24'h123456, 7'd100, 1'b1, 7'd10, 17'd100);
    // zero curve entry darkens the whole ring: global forced off at 100 %
    send_op(MODE_STAGE_ALL, 4'd0,  24'hFFFFFF, 7'd0,   1'b0, 7'd0,   17'd0);
    send_op(MODE_COMMIT,    4'd0,  24'h000000, 7'd100, 1'b0, 7'd0,   17'd0);
    drain_results();

    curve_loaded.push_back(7'd50);
    curve_loaded.push_back(7'd99);
    curve_loaded.push_back(7'd100);

    // Random, both sides idling.
    send_random(150);

    // Back to back, no idling anywhere.
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_random(80);

    // Receiver holds off while the sender keeps offering requests, so the
    // queue fills and the input stalls.
    hold_cycles = HOLD_CYCLES;
    send_random(40);
    drain_results();

    // Mixed stretches: idling switched per block of requests.
    for (int blk = 0; blk < 8; blk++) begin
      tx_idle = 1'($urandom);
      rx_idle = 1'($urandom);
      send_random(25);
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (DRAIN_TAIL) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
